// File: design/ackfp_pkg.sv
// Package for the ACK frame parser: phase, result kind and error code types,
// frame type bytes and the result record passed from the core to the top level.
// No dependencies.
package ackfp_pkg;

  // Frame type bytes
  localparam logic [7:0] TYPE_ACK     = 8'h02;
  localparam logic [7:0] TYPE_ACK_ECN = 8'h03;

  // Ack delay shift used when the register holds zero
  localparam logic [4:0] DEFAULT_EXPONENT = 5'd3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LARGEST,
    PH_DELAY,
    PH_COUNT,
    PH_FIRST,
    PH_GAP,
    PH_LEN,
    PH_ECT0,
    PH_ECT1,
    PH_CE
  } phase_e;

  typedef enum logic [2:0] {
    K_RANGE = 3'd0,
    K_DELAY = 3'd1,
    K_ECT0  = 3'd2,
    K_ECT1  = 3'd3,
    K_CE    = 3'd4,
    K_ERROR = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_TYPE  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [63:0] value_a;
    logic [61:0] value_b;
    err_e        err;
    logic        done;
  } result_t;

endpackage

// File: design/ackfp_core.sv
// Decode core of the ACK frame parser: frame state, varint collection and
// range arithmetic for one byte per cycle while step_i is high. Depends on ackfp_pkg.
module ackfp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_start_i,
  input  logic                 buffer_end_i,
  input  logic [4:0]           exponent_i,
  output ackfp_pkg::result_t   result_o
);

  ackfp_pkg::phase_e phase_q, phase_d;
  logic [61:0] accum_q, accum_d;
  logic [2:0]  left_q, left_d;
  logic [61:0] largest_q, largest_d;
  logic [61:0] smallest_q, smallest_d;
  logic [61:0] ranges_q, ranges_d;
  logic [61:0] top_q, top_d;
  logic        ecn_q, ecn_d;

  logic [61:0] acc_new;
  logic [2:0]  left_new;
  logic        complete;
  logic [62:0] first_diff;
  logic [63:0] gap_diff;
  logic [62:0] len_diff;
  logic [61:0] ranges_dec;
  logic [4:0]  shift;
  logic [63:0] delay_val;
  logic        errored;
  logic        more_ranges;

  // Collect the next varint byte
  always_comb begin
    if (left_q == 3'd0) begin
      acc_new = {56'd0, data_byte_i[5:0]};
      case (data_byte_i[7:6])
        2'd0:    left_new = 3'd0;
        2'd1:    left_new = 3'd1;
        2'd2:    left_new = 3'd3;
        default: left_new = 3'd7;
      endcase
    end else begin
      acc_new  = {accum_q[53:0], data_byte_i};
      left_new = left_q - 3'd1;
    end
    complete = (left_new == 3'd0);
  end

  // Range arithmetic, one subtract and borrow check per phase
  assign first_diff = {1'b0, largest_q} - {1'b0, acc_new};
  assign gap_diff   = {2'b00, smallest_q} - {2'b00, acc_new} - 64'd2;
  assign len_diff   = {1'b0, top_q} - {1'b0, acc_new};
  assign ranges_dec = ranges_q - 62'd1;
  assign shift      = (exponent_i == 5'd0) ? ackfp_pkg::DEFAULT_EXPONENT : exponent_i;
  assign delay_val  = {2'b00, acc_new} << shift;

  // Next state and result
  always_comb begin
    phase_d    = phase_q;
    accum_d    = accum_q;
    left_d     = left_q;
    largest_d  = largest_q;
    smallest_d = smallest_q;
    ranges_d   = ranges_q;
    top_d      = top_q;
    ecn_d      = ecn_q;
    errored    = 1'b0;
    more_ranges = 1'b0;
    result_o   = '0;
    result_o.kind = ackfp_pkg::K_RANGE;
    result_o.err  = ackfp_pkg::ERR_NONE;

    if (step_i) begin
      if (frame_start_i) begin
        // Type byte: restart regardless of the frame in progress
        left_d  = 3'd0;
        accum_d = '0;
        if (data_byte_i == ackfp_pkg::TYPE_ACK || data_byte_i == ackfp_pkg::TYPE_ACK_ECN) begin
          ecn_d   = data_byte_i[0];
          phase_d = ackfp_pkg::PH_LARGEST;
        end else begin
          phase_d         = ackfp_pkg::PH_IDLE;
          result_o.valid  = 1'b1;
          result_o.kind   = ackfp_pkg::K_ERROR;
          result_o.err    = ackfp_pkg::ERR_BAD_TYPE;
          result_o.done   = 1'b1;
        end
      end else if (phase_q != ackfp_pkg::PH_IDLE) begin
        accum_d = acc_new;
        left_d  = left_new;
        if (complete) begin
          case (phase_q)
            ackfp_pkg::PH_LARGEST: begin
              largest_d = acc_new;
              phase_d   = ackfp_pkg::PH_DELAY;
            end
            ackfp_pkg::PH_DELAY: begin
              result_o.valid   = 1'b1;
              result_o.kind    = ackfp_pkg::K_DELAY;
              result_o.value_a = delay_val;
              phase_d          = ackfp_pkg::PH_COUNT;
            end
            ackfp_pkg::PH_COUNT: begin
              ranges_d = acc_new;
              phase_d  = ackfp_pkg::PH_FIRST;
            end
            ackfp_pkg::PH_FIRST: begin
              if (first_diff[62]) begin
                errored = 1'b1;
              end else begin
                smallest_d       = first_diff[61:0];
                result_o.valid   = 1'b1;
                result_o.kind    = ackfp_pkg::K_RANGE;
                result_o.value_a = {2'b00, first_diff[61:0]};
                result_o.value_b = largest_q;
                more_ranges      = (ranges_q != 62'd0);
              end
            end
            ackfp_pkg::PH_GAP: begin
              // Keep the largest of the next range rather than the gap
              if (gap_diff[63]) begin
                errored = 1'b1;
              end else begin
                top_d   = gap_diff[61:0];
                phase_d = ackfp_pkg::PH_LEN;
              end
            end
            ackfp_pkg::PH_LEN: begin
              if (len_diff[62]) begin
                errored = 1'b1;
              end else begin
                smallest_d       = len_diff[61:0];
                ranges_d         = ranges_dec;
                result_o.valid   = 1'b1;
                result_o.kind    = ackfp_pkg::K_RANGE;
                result_o.value_a = {2'b00, len_diff[61:0]};
                result_o.value_b = top_q;
                more_ranges      = (ranges_dec != 62'd0);
              end
            end
            ackfp_pkg::PH_ECT0: begin
              result_o.valid   = 1'b1;
              result_o.kind    = ackfp_pkg::K_ECT0;
              result_o.value_a = {2'b00, acc_new};
              phase_d          = ackfp_pkg::PH_ECT1;
            end
            ackfp_pkg::PH_ECT1: begin
              result_o.valid   = 1'b1;
              result_o.kind    = ackfp_pkg::K_ECT1;
              result_o.value_a = {2'b00, acc_new};
              phase_d          = ackfp_pkg::PH_CE;
            end
            default: begin
              result_o.valid   = 1'b1;
              result_o.kind    = ackfp_pkg::K_CE;
              result_o.value_a = {2'b00, acc_new};
              result_o.done    = 1'b1;
              phase_d          = ackfp_pkg::PH_IDLE;
            end
          endcase

          // Choose what follows a range
          if (result_o.valid && result_o.kind == ackfp_pkg::K_RANGE) begin
            if (more_ranges) begin
              phase_d = ackfp_pkg::PH_GAP;
            end else if (ecn_q) begin
              phase_d = ackfp_pkg::PH_ECT0;
            end else begin
              phase_d       = ackfp_pkg::PH_IDLE;
              result_o.done = 1'b1;
            end
          end
        end
      end

      // Underflow wins, then truncation replaces any other result while the frame is still open
      if (errored) begin
        phase_d          = ackfp_pkg::PH_IDLE;
        left_d           = 3'd0;
        result_o         = '0;
        result_o.valid   = 1'b1;
        result_o.kind    = ackfp_pkg::K_ERROR;
        result_o.err     = ackfp_pkg::ERR_UNDERFLOW;
        result_o.done    = 1'b1;
      end else if (buffer_end_i && phase_d != ackfp_pkg::PH_IDLE) begin
        phase_d          = ackfp_pkg::PH_IDLE;
        left_d           = 3'd0;
        result_o         = '0;
        result_o.valid   = 1'b1;
        result_o.kind    = ackfp_pkg::K_ERROR;
        result_o.err     = ackfp_pkg::ERR_TRUNCATED;
        result_o.done    = 1'b1;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ackfp_pkg::PH_IDLE;
      accum_q    <= '0;
      left_q     <= '0;
      largest_q  <= '0;
      smallest_q <= '0;
      ranges_q   <= '0;
      top_q      <= '0;
      ecn_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      accum_q    <= accum_d;
      left_q     <= left_d;
      largest_q  <= largest_d;
      smallest_q <= smallest_d;
      ranges_q   <= ranges_d;
      top_q      <= top_d;
      ecn_q      <= ecn_d;
    end
  end

endmodule

// File: design/ack_frame_parser.sv
// Each byte moves from the input register into the result register when the core steps,
// and its result then transfers out of the result register.
// Throughput: one byte per cycle, set by the single decode pass in ackfp_core;
// output stalls back up through the result register. Reset (rst_ni low, asynchronous)
// empties both registers, puts the parser in idle and sets the ack delay exponent to 3.
// Top level of the ACK frame parser; uses ackfp_pkg and ackfp_core.
module ack_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [63:0] value_a_o,
  output logic [61:0] value_b_o,
  output logic [1:0]  err_code_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        start_q;
  logic        end_q;
  logic [4:0]  exponent_q;
  logic        step;
  ackfp_pkg::result_t res;
  ackfp_pkg::result_t out_q;

  // Process the held byte when the result register is free or draining
  assign step        = in_valid_q && (!out_q.valid || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= ackfp_pkg::DEFAULT_EXPONENT;
    end else if (cfg_valid_i) begin
      exponent_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= data_byte_i;
      start_q <= frame_start_i;
      end_q   <= buffer_end_i;
    end
  end

  ackfp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (byte_q),
    .frame_start_i (start_q),
    .buffer_end_i  (end_q),
    .exponent_i    (exponent_q),
    .result_o      (res)
  );

  // Result register: load on a step, drop after the output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (step) begin
      out_q <= res;
    end else if (out_ready_i) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_valid_o  = out_q.valid;
  assign kind_o       = out_q.kind;
  assign value_a_o    = out_q.value_a;
  assign value_b_o    = out_q.value_b;
  assign err_code_o   = out_q.err;
  assign frame_done_o = out_q.done;

`ifndef NO_ASSERTIONS
  a_error_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ackfp_pkg::K_ERROR |-> frame_done_o)
    else $error("error result without frame_done");

  a_code_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == ackfp_pkg::K_ERROR) == (err_code_o != ackfp_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  a_range_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ackfp_pkg::K_RANGE |->
      value_a_o[63:62] == 2'b00 && value_a_o[61:0] <= value_b_o)
    else $error("range smallest above largest");

  a_value_b_only_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != ackfp_pkg::K_RANGE |-> value_b_o == 62'd0)
    else $error("value_b set on a non-range result");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output is free");
`endif

endmodule
